// ===== rtl/core/pts_pkg.sv =====
// shared constants and types for the priority task scheduler
// no dependencies
package pts_pkg;
    localparam int MAX_TASKS    = 8;
    localparam int MAX_SEMS     = 8;
    localparam int MAX_QUEUES   = 4;
    localparam int QUEUE_SLOTS  = 16;
    localparam int TASK_ENTRIES = MAX_TASKS + 1;
    localparam int TW = 4;
    localparam int SW = 4;
    localparam int QW = 3;
    localparam int SLOT_W = 4;
    localparam int QIDX_W = 2;
    localparam int MADDR_W = QIDX_W + SLOT_W;
    localparam int LEN_W = 5;

    localparam logic [2:0] K_NEW_TASK = 3'd0;
    localparam logic [2:0] K_RUN      = 3'd1;
    localparam logic [2:0] K_SEM_NEW  = 3'd2;
    localparam logic [2:0] K_SEM_PEND = 3'd3;
    localparam logic [2:0] K_SEM_POST = 3'd4;
    localparam logic [2:0] K_Q_NEW    = 3'd5;
    localparam logic [2:0] K_Q_POST   = 3'd6;
    localparam logic [2:0] K_Q_PEND   = 3'd7;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_SEM   = 2'd1;
    localparam logic [1:0] ST_QUEUE = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_SAT  = 2'd2;

    localparam logic [TW-1:0] NO_TASK = 4'hF;

    typedef struct packed {
        logic [1:0] state;
        logic [2:0] obj;
    } t_task;

    // task table access from the sequencer
    typedef struct packed {
        logic          we;
        logic [TW-1:0] waddr;
        t_task         wdata;
        logic [TW-1:0] raddr;
    } t_tbl_req;
endpackage

// ===== rtl/core/pts_task_ram.sv =====
// task table memory: state and wait object per task, one read and one write port
// depends on pts_pkg
module pts_task_ram (
    input  logic              i_clk,
    input  pts_pkg::t_tbl_req i_req,
    output pts_pkg::t_task    o_rdata
);
    import pts_pkg::*;
    t_task r_mem [TASK_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// ===== rtl/core/pts_msg_ram.sv =====
// message ring storage for all queues, one read and one write port
// depends on pts_pkg
module pts_msg_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [pts_pkg::MADDR_W-1:0] i_waddr,
    input  logic [15:0]                i_wdata,
    input  logic [pts_pkg::MADDR_W-1:0] i_raddr,
    output logic [15:0]                o_rdata
);
    import pts_pkg::*;
    logic [15:0] r_mem [MAX_QUEUES*QUEUE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/priority_task_scheduler_sync.sv =====
// top level of the priority task scheduler: command sequencer, task walk,
// semaphore and queue bookkeeping; depends on pts_pkg, pts_task_ram, pts_msg_ram
//
// channel  | direction | handshake               | fields
// command  | in        | start & !busy           | kind obj_index init_value ring_size message
// result   | out       | o_done strobe, 1 cycle  | running_task task_switched handle
//          |           |                         | message_out blocked status
//
// walks: a post walks the task table once to wake a waiter and once to pick the
// newest ready task, a run or blocking pend walks it once, one entry per cycle
// through the single read port
// reset: synchronous active low; task memory needs no clear since only
// entries below the task count are read and each is written at create
// (task 0 is written in state S_INIT after reset, see below)
// stalls: none; the result strobe is unconditional, busy holds off commands
module priority_task_scheduler_sync (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_obj_index,
    input  logic signed [7:0] i_init_value,
    input  logic [4:0]  i_ring_size,
    input  logic [15:0] i_message,
    output logic        busy,
    output logic        o_done,
    output logic [3:0]  o_running_task,
    output logic        o_task_switched,
    output logic [3:0]  o_handle,
    output logic [15:0] o_message_out,
    output logic        o_blocked,
    output logic [1:0]  o_status
);
    import pts_pkg::*;

    // sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;  // write idle task entry
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WAKE  = 3'd2;  // walk down looking for a waiter
    localparam logic [2:0] S_SCHED = 3'd3;  // walk down looking for ready task
    localparam logic [2:0] S_MSG   = 3'd4;  // message read data arrives

    logic [2:0] r_state, n_state;

    // small register state (few entries, indexed by command)
    logic [TW-1:0] r_task_total, n_task_total;
    logic [TW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_sem_total, n_sem_total;
    logic [QW-1:0] r_q_total, n_q_total;
    logic [7:0]    r_sem [MAX_SEMS];
    logic [LEN_W-1:0] r_qlen [MAX_QUEUES];
    logic [SLOT_W-1:0] r_wp [MAX_QUEUES];
    logic [SLOT_W-1:0] r_rp [MAX_QUEUES];
    logic [LEN_W-1:0] r_fill [MAX_QUEUES];

    // command latch
    logic [2:0] r_kind;
    logic [2:0] r_obj;

    // walk state
    logic [TW-1:0] r_idx, n_idx;     // entry whose data arrives this cycle
    logic          r_rvalid, n_rvalid;

    // result
    logic        r_done, n_done;
    logic [3:0]  r_handle, n_handle;
    logic [15:0] r_msg_out, n_msg_out;
    logic        r_blocked, n_blocked;
    logic [1:0]  r_status, n_status;
    logic        r_sw, n_sw;

    t_tbl_req tbl_req;
    t_task    tbl_rdata;
    logic [15:0] msg_rdata;
    logic        msg_we;
    logic [MADDR_W-1:0] msg_waddr, msg_raddr;

    pts_task_ram u_task (.i_clk(i_clk), .i_req(tbl_req), .o_rdata(tbl_rdata));
    pts_msg_ram  u_msg (
        .i_clk(i_clk), .i_we(msg_we), .i_waddr(msg_waddr), .i_wdata(i_message),
        .i_raddr(msg_raddr), .o_rdata(msg_rdata)
    );

    logic accept;
    assign accept = start && !busy;

    logic [QIDX_W-1:0] qi;
    assign qi = i_obj_index[QIDX_W-1:0];

    logic sem_ok, q_ok, can_block;
    assign sem_ok = {1'b0, i_obj_index} < r_sem_total;
    assign q_ok   = i_obj_index < r_q_total;
    assign can_block = (r_cur != NO_TASK) && (r_cur != '0) && (r_cur < r_task_total);

    logic [LEN_W-1:0] rsize_clip;
    always_comb begin
        if (i_ring_size == '0) begin
            rsize_clip = LEN_W'(1);
        end else if (i_ring_size > LEN_W'(QUEUE_SLOTS)) begin
            rsize_clip = LEN_W'(QUEUE_SLOTS);
        end else begin
            rsize_clip = i_ring_size;
        end
    end

    // wake match on the entry under the walk
    logic [1:0] wait_kind;
    assign wait_kind = (r_kind == K_SEM_POST) ? ST_SEM : ST_QUEUE;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_task_total = r_task_total;
        n_cur        = r_cur;
        n_sem_total  = r_sem_total;
        n_q_total    = r_q_total;
        n_idx        = r_idx;
        n_rvalid     = 1'b0;
        n_done       = 1'b0;
        n_handle     = r_handle;
        n_msg_out    = r_msg_out;
        n_blocked    = r_blocked;
        n_status     = r_status;
        n_sw         = r_sw;
        tbl_req      = '0;
        msg_we       = 1'b0;
        msg_waddr    = {qi, r_wp[qi]};
        msg_raddr    = {qi, r_rp[qi]};

        case (r_state)
            S_INIT: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = '0;
                tbl_req.wdata = '{state: ST_READY, obj: 3'd0};
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_handle  = '0;
                    n_msg_out = '0;
                    n_blocked = 1'b0;
                    n_status  = STS_OK;
                    n_sw      = 1'b0;
                    n_done    = 1'b1;
                    case (i_kind)
                        K_NEW_TASK: begin
                            if (r_task_total >= TW'(TASK_ENTRIES)) begin
                                n_status = STS_FULL;
                            end else begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = r_task_total;
                                tbl_req.wdata = '{state: ST_READY, obj: 3'd0};
                                n_handle      = r_task_total;
                                n_task_total  = r_task_total + 1'b1;
                            end
                        end
                        K_RUN: begin
                            n_done = 1'b0;
                            n_idx  = r_task_total;
                            n_state = S_SCHED;
                        end
                        K_SEM_NEW: begin
                            if (r_sem_total >= SW'(MAX_SEMS)) begin
                                n_status = STS_FULL;
                            end else begin
                                n_handle    = r_sem_total;
                                n_sem_total = r_sem_total + 1'b1;
                            end
                        end
                        K_SEM_PEND: begin
                            if (sem_ok && (r_sem[i_obj_index] == '0
                                    || r_sem[i_obj_index][7]) && can_block) begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = r_cur;
                                tbl_req.wdata = '{state: ST_SEM, obj: i_obj_index};
                                n_blocked     = 1'b1;
                                n_done        = 1'b0;
                                n_idx         = r_task_total;
                                n_state       = S_SCHED;
                            end
                        end
                        K_SEM_POST: begin
                            if (sem_ok) begin
                                if (r_sem[i_obj_index] == 8'h7F) begin
                                    n_status = STS_SAT;
                                end
                                n_done  = 1'b0;
                                n_idx   = r_task_total;
                                n_state = S_WAKE;
                            end
                        end
                        K_Q_NEW: begin
                            if (r_q_total >= QW'(MAX_QUEUES)) begin
                                n_status = STS_FULL;
                            end else begin
                                n_handle  = TW'(r_q_total);
                                n_q_total = r_q_total + 1'b1;
                            end
                        end
                        K_Q_POST: begin
                            if (q_ok) begin
                                if (r_fill[qi] >= r_qlen[qi]) begin
                                    n_status = STS_FULL;
                                end else begin
                                    msg_we = 1'b1;
                                end
                                n_done  = 1'b0;
                                n_idx   = r_task_total;
                                n_state = S_WAKE;
                            end
                        end
                        default: begin
                            if (q_ok) begin
                                if (r_fill[qi] != '0) begin
                                    // message read issued at this transfer
                                    n_done  = 1'b0;
                                    n_state = S_MSG;
                                end else if (can_block) begin
                                    tbl_req.we    = 1'b1;
                                    tbl_req.waddr = r_cur;
                                    tbl_req.wdata = '{state: ST_QUEUE, obj: i_obj_index};
                                    n_blocked     = 1'b1;
                                    n_done        = 1'b0;
                                    n_idx         = r_task_total;
                                    n_state       = S_SCHED;
                                end
                            end
                        end
                    endcase
                end
            end
            S_MSG: begin
                n_msg_out = msg_rdata;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_WAKE: begin
                // issue read of r_idx-1 when above 1, check data of previous
                if (r_rvalid && tbl_rdata.state == wait_kind && tbl_rdata.obj == r_obj) begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = r_idx;
                    tbl_req.wdata = '{state: ST_READY, obj: tbl_rdata.obj};
                    n_idx         = r_task_total;
                    n_state       = S_SCHED;
                end else if (r_idx > TW'(1)) begin
                    n_idx         = r_idx - 1'b1;
                    tbl_req.raddr = r_idx - 1'b1;
                    n_rvalid      = 1'b1;
                end else begin
                    n_idx   = r_task_total;
                    n_state = S_SCHED;
                end
            end
            S_SCHED: begin
                if (r_rvalid && tbl_rdata.state == ST_READY) begin
                    n_cur   = r_idx;
                    n_sw    = r_idx != r_cur;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_idx > TW'(1)) begin
                    n_idx         = r_idx - 1'b1;
                    tbl_req.raddr = r_idx - 1'b1;
                    n_rvalid      = 1'b1;
                end else begin
                    n_cur   = '0;
                    n_sw    = r_cur != '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_task_total <= TW'(1);
            r_cur        <= NO_TASK;
            r_sem_total  <= '0;
            r_q_total    <= '0;
            r_rvalid     <= 1'b0;
            r_done       <= 1'b0;
            for (int q = 0; q < MAX_QUEUES; q++) begin
                r_wp[q]   <= '0;
                r_rp[q]   <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_task_total <= n_task_total;
            r_cur        <= n_cur;
            r_sem_total  <= n_sem_total;
            r_q_total    <= n_q_total;
            r_rvalid     <= n_rvalid;
            r_done       <= n_done;
            if (accept) begin
                case (i_kind)
                    K_Q_NEW: begin
                        if (r_q_total < QW'(MAX_QUEUES)) begin
                            r_wp[r_q_total[QIDX_W-1:0]]   <= '0;
                            r_rp[r_q_total[QIDX_W-1:0]]   <= '0;
                            r_fill[r_q_total[QIDX_W-1:0]] <= '0;
                        end
                    end
                    K_Q_POST: begin
                        if (q_ok && r_fill[qi] < r_qlen[qi]) begin
                            r_wp[qi] <= ({1'b0, r_wp[qi]} + 1'b1 < r_qlen[qi])
                                ? r_wp[qi] + 1'b1 : '0;
                            r_fill[qi] <= r_fill[qi] + 1'b1;
                        end
                    end
                    K_Q_PEND: begin
                        if (q_ok && r_fill[qi] != '0) begin
                            r_rp[qi] <= ({1'b0, r_rp[qi]} + 1'b1 < r_qlen[qi])
                                ? r_rp[qi] + 1'b1 : '0;
                            r_fill[qi] <= r_fill[qi] - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_handle  <= n_handle;
        r_msg_out <= n_msg_out;
        r_blocked <= n_blocked;
        r_status  <= n_status;
        r_sw      <= n_sw;
        if (accept) begin
            r_kind <= i_kind;
            r_obj  <= i_obj_index;
            case (i_kind)
                K_SEM_NEW: begin
                    if (r_sem_total < SW'(MAX_SEMS)) begin
                        r_sem[r_sem_total[2:0]] <= i_init_value;
                    end
                end
                K_SEM_PEND: begin
                    if (sem_ok && r_sem[i_obj_index] != '0 && !r_sem[i_obj_index][7]) begin
                        r_sem[i_obj_index] <= r_sem[i_obj_index] - 1'b1;
                    end
                end
                K_SEM_POST: begin
                    if (sem_ok && r_sem[i_obj_index] != 8'h7F) begin
                        r_sem[i_obj_index] <= r_sem[i_obj_index] + 1'b1;
                    end
                end
                K_Q_NEW: begin
                    if (r_q_total < QW'(MAX_QUEUES)) begin
                        r_qlen[r_q_total[QIDX_W-1:0]] <= rsize_clip;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE) || r_done;
    assign o_done          = r_done;
    assign o_running_task  = r_cur;
    assign o_task_switched = r_sw;
    assign o_handle        = r_handle;
    assign o_message_out   = r_msg_out;
    assign o_blocked       = r_blocked;
    assign o_status        = r_status;
endmodule

// ===== rtl/core/pts_checker.sv =====
// port-level checks for the priority task scheduler
// depends on priority_task_scheduler_sync
module pts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [3:0] o_running_task,
    input logic       o_task_switched,
    input logic       o_blocked,
    input logic [1:0] o_status
);
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("command not taken");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3) else $error("bad status");
    a_block_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_blocked) |-> o_task_switched) else $error("block without switch");
    a_task_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_running_task <= 4'd8 || o_running_task == 4'd15))
        else $error("running task out of range");
endmodule

bind priority_task_scheduler_sync pts_checker u_pts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_running_task(o_running_task),
    .o_task_switched(o_task_switched), .o_blocked(o_blocked), .o_status(o_status)
);
